// ===== rtl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types, command codes and constant dividers for the servo position
// ramp.
// ----------------------------------------------------------------------------
package spr_pkg;

	localparam int CMD_W = 2;
	localparam int UNITS_W = 10;
	localparam int SPEED_W = 11;
	localparam int TENTHS_W = 14;
	localparam int POS_W = 11;

	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;
	localparam logic [CMD_W-1:0] CMD_QUICK = 2'd3;

	localparam logic [0:0] REG_LOWER = 1'd0;
	localparam logic [0:0] REG_UPPER = 1'd1;

	// Reciprocals in 0.16 fixed point, rounded up so that truncation is exact
	// over the 14-bit and 15-bit operand ranges in use.
	localparam logic [15:0] RECIP_10 = 16'd6554;
	localparam logic [15:0] RECIP_5 = 16'd13108;

	typedef logic signed [TENTHS_W-1:0] tenths_t;
	typedef logic signed [UNITS_W-1:0] units_t;
	typedef logic signed [POS_W-1:0] pos_t;

	// Division by ten, truncated toward zero.
	function automatic pos_t div10(input tenths_t x);
		logic [13:0] mag;
		logic [29:0] prod;
		logic [10:0] q;
		mag = x[13] ? 14'(-x) : 14'(x);
		prod = 30'(mag) * 30'(RECIP_10);
		q = prod[26:16];
		return x[13] ? pos_t'(-q) : pos_t'(q);
	endfunction

	// Division by five, truncated toward zero.
	function automatic logic signed [11:0] div5(input logic signed [14:0] d);
		logic [14:0] mag;
		logic [30:0] prod;
		logic [11:0] q;
		mag = d[14] ? 15'(-d) : 15'(d);
		prod = 31'(mag) * 31'(RECIP_5);
		q = prod[27:16];
		return d[14] ? 12'(-q) : 12'(q);
	endfunction

	// Ten times a whole-unit value, as tenths.
	function automatic tenths_t times10(input units_t u);
		tenths_t w;
		w = tenths_t'(u);
		return (w <<< 3) + (w <<< 1);
	endfunction

endpackage

// ===== rtl/servo_position_ramp.sv =====
// A result passes through the s1, s2 and s3 registers after its input transfer.
// Throughput: one command per cycle while the result side is not stalled; the
// position update is a combinational add-and-clamp on the state registers, so
// commands may follow back to back. A stall on the result side holds the whole
// three-register pipeline. Reset (arst_n low) clears position, target and speed
// to zero and loads the window limits with -42 and 90.
// ----------------------------------------------------------------------------
// servo_position_ramp
// Servo setpoint stepper: moves a position in tenths toward a target under a
// speed limit and a configurable window.
// ----------------------------------------------------------------------------
module servo_position_ramp
	import spr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // target[9:0], speed[20:10], zero pad
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // position_tenths[13:0], position[24:14],
	                               // at_target[25], zero pad
);

	units_t lower_q, upper_q;
	tenths_t cur_q;
	units_t target_q;
	logic [SPEED_W-1:0] speed_q;

	logic en;
	logic valid_s1, valid_s2, valid_s3;
	logic [CMD_W-1:0] cmd_s1;
	units_t tgt_s1;
	logic [SPEED_W-1:0] speed_s1;
	tenths_t tenths_s2;
	units_t target_s2;
	tenths_t tenths_s3;
	pos_t pos_s3;
	logic at_target_s3;

	pos_t cur_units;
	tenths_t tgt_x10, lo_x10, hi_x10;
	logic signed [14:0] diff;
	logic signed [12:0] step_raw, step, sp;
	logic signed [15:0] sum;
	tenths_t clamped;
	tenths_t cur_d;
	units_t target_d;
	logic [SPEED_W-1:0] speed_d;
	pos_t pos_new;

	// The pipeline moves as one while the result register is free or drained.
	assign en = !valid_s3 || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= -10'sd42;
			upper_q <= 10'sd90;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOWER: lower_q <= cfg_data;
				REG_UPPER: upper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= s_tuser;
			tgt_s1 <= s_tdata[9:0];
			speed_s1 <= s_tdata[20:10];
			tenths_s2 <= cur_d;
			target_s2 <= target_d;
			tenths_s3 <= tenths_s2;
			pos_s3 <= pos_new;
			at_target_s3 <= (pos_new == pos_t'(target_s2));
		end
	end

	// Step calculation on the current state.
	always_comb begin
		cur_units = div10(cur_q);
		tgt_x10 = times10(target_q);
		lo_x10 = times10(lower_q);
		hi_x10 = times10(upper_q);
		diff = 15'(tgt_x10) - 15'(cur_q);
		step_raw = 13'(div5(diff)) + 13'sd5;
		sp = $signed({2'b00, speed_q});
		if (step_raw > sp) begin
			step = sp;
		end else if (step_raw < -sp) begin
			step = -sp;
		end else begin
			step = step_raw;
		end
		sum = 16'(cur_q) + 16'(step);
		// With an inverted window the lower bound wins only for sums below it.
		if (sum < 16'(lo_x10)) begin
			clamped = lo_x10;
		end else if (sum > 16'(hi_x10)) begin
			clamped = hi_x10;
		end else begin
			clamped = sum[13:0];
		end
	end

	always_comb begin
		cur_d = cur_q;
		target_d = target_q;
		speed_d = speed_q;
		case (cmd_s1)
			CMD_TICK: begin
				if (cur_units != pos_t'(target_q)) begin
					cur_d = clamped;
				end
			end
			CMD_SET: begin
				target_d = tgt_s1;
				speed_d = speed_s1;
			end
			CMD_STOP: begin
				target_d = cur_units[9:0];
				speed_d = '0;
			end
			CMD_QUICK: begin
				cur_d = tgt_x10;
				speed_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			target_q <= '0;
			speed_q <= '0;
		end else if (en && valid_s1) begin
			cur_q <= cur_d;
			target_q <= target_d;
			speed_q <= speed_d;
		end
	end

	assign pos_new = div10(tenths_s2);

	assign m_tvalid = valid_s3;
	assign m_tdata = {6'b0, at_target_s3, pos_s3, tenths_s3};

endmodule

// ===== verif/tb_servo_position_ramp.sv =====
// ----------------------------------------------------------------------------
// tb_servo_position_ramp
// Self-checking bench for the servo position ramp. Commands go in over the
// input stream and the returned positions are compared with a behavioural
// model of the stepper. The window limits are changed between phases, and
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_servo_position_ramp;
	timeunit 1ns;
	timeprecision 1ps;
	import spr_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_LOWER;
	logic [9:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // target[9:0], speed[20:10], zero pad
	logic [1:0]  s_tuser = CMD_TICK;   // command[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // position_tenths[13:0], position[24:14],
	                             // at_target[25], zero pad

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_cycles = 0;

	typedef struct {
		tenths_t tenths;
		pos_t    pos;
		logic    at_target;
	} ramp_result_t;

	class ramp_scoreboard;
		int lower_units;
		int upper_units;
		int cur_tenths;
		int target_units;
		int speed_max;
		int errors;
		ramp_result_t awaited[$];

		function new();
			lower_units = -42;
			upper_units = 90;
			cur_tenths = 0;
			target_units = 0;
			speed_max = 0;
			errors = 0;
		endfunction

		function void set_window(int lo, int hi);
			lower_units = lo;
			upper_units = hi;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Advances the stepper by one command and queues the position it reports.
		function void note_command(logic [CMD_W-1:0] cmd, logic [23:0] data);
			units_t             new_target;
			logic [SPEED_W-1:0] new_speed;
			int                 step;
			ramp_result_t       r;
			new_target = data[9:0];
			new_speed = data[20:10];
			case (cmd)
				CMD_TICK: begin
					if (cur_tenths / 10 != target_units) begin
						step = (10 * target_units - cur_tenths) / 5 + 5;
						if (step > speed_max)
							step = speed_max;
						else if (step < -speed_max)
							step = -speed_max;
						cur_tenths += step;
						// With an inverted window the lower bound wins only for values below it.
						if (cur_tenths < 10 * lower_units)
							cur_tenths = 10 * lower_units;
						else if (cur_tenths > 10 * upper_units)
							cur_tenths = 10 * upper_units;
					end
				end
				CMD_SET: begin
					target_units = new_target;
					speed_max = new_speed;
				end
				CMD_STOP: begin
					target_units = cur_tenths / 10;
					speed_max = 0;
				end
				CMD_QUICK: begin
					cur_tenths = 10 * target_units;
					speed_max = 0;
				end
				default: ;
			endcase
			r.tenths = tenths_t'(cur_tenths);
			r.pos = pos_t'(cur_tenths / 10);
			r.at_target = (cur_tenths / 10 == target_units);
			awaited.push_back(r);
		endfunction

		function void check_result(logic [31:0] data);
			ramp_result_t want;
			ramp_result_t got;
			got.tenths = data[13:0];
			got.pos = data[24:14];
			got.at_target = data[25];
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%t: unexpected result, tdata %h", $realtime, data);
				return;
			end
			want = awaited.pop_front();
			if (got.tenths !== want.tenths || got.pos !== want.pos ||
			    got.at_target !== want.at_target) begin
				errors++;
				if (errors <= 10)
					$display("%t: mismatch tenths %0d/%0d position %0d/%0d at_target %0b/%0b (expected/actual)",
					         $realtime, want.tenths, got.tenths, want.pos, got.pos,
					         want.at_target, got.at_target);
			end
		endfunction
	endclass

	ramp_scoreboard sb = new();

	servo_position_ramp dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// A requested hold-off is counted down here, once per edge, with ready held low.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles--;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	function automatic units_t rand_units();
		return units_t'($urandom_range(1023));
	endfunction

	task automatic send_cmd(logic [CMD_W-1:0] cmd, units_t tgt, logic [SPEED_W-1:0] spd);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {3'b000, spd, tgt};
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, {3'b000, spd, tgt});
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_window(int lo, int hi);
		cfg_we <= 1'b1;
		cfg_index <= REG_LOWER;
		cfg_data <= lo[9:0];
		@(posedge clk);
		cfg_index <= REG_UPPER;
		cfg_data <= hi[9:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_window(lo, hi);
	endtask

	// Mostly a set followed by a run of ticks, sometimes ended by a stop or a
	// quick move; the rest is commands with entirely random content.
	task automatic run_random(int n_items);
		int                 done;
		units_t             tgt;
		logic [SPEED_W-1:0] spd;
		done = 0;
		while (done < n_items) begin
			if ($urandom_range(99) < 80) begin
				if (sb.lower_units <= sb.upper_units && $urandom_range(1) == 1)
					tgt = units_t'(sb.lower_units +
					               $urandom_range(sb.upper_units - sb.lower_units));
				else
					tgt = rand_units();
				case ($urandom_range(2))
					0: spd = SPEED_W'($urandom_range(40));
					1: spd = SPEED_W'($urandom_range(400));
					default: spd = SPEED_W'($urandom_range(2047));
				endcase
				send_cmd(CMD_SET, tgt, spd);
				done++;
				repeat ($urandom_range(1, 14)) begin
					send_cmd(CMD_TICK, rand_units(), SPEED_W'($urandom));
					done++;
				end
				case ($urandom_range(5))
					0: begin
						send_cmd(CMD_STOP, rand_units(), SPEED_W'($urandom));
						done++;
					end
					1: begin
						send_cmd(CMD_QUICK, rand_units(), SPEED_W'($urandom));
						done++;
					end
					default: ;
				endcase
			end else begin
				send_cmd(CMD_W'($urandom), rand_units(), SPEED_W'($urandom));
				done++;
			end
		end
	endtask

	initial begin
		int p;
		int lo;
		int hi;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the window left at its reset values.
		send_cmd(CMD_TICK, 10'sd0, 11'd0);
		send_cmd(CMD_SET, 10'sd511, 11'd2047);
		send_cmd(CMD_TICK, 10'sd0, 11'd0);
		send_cmd(CMD_TICK, 10'sd0, 11'd0);
		send_cmd(CMD_SET, -10'sd512, 11'd0);
		send_cmd(CMD_TICK, 10'sd0, 11'd0);
		send_cmd(CMD_SET, -10'sd512, 11'd2047);
		send_cmd(CMD_TICK, 10'sd0, 11'd0);
		send_cmd(CMD_TICK, 10'sd0, 11'd0);
		send_cmd(CMD_STOP, 10'sd511, 11'd2047);
		send_cmd(CMD_QUICK, -10'sd512, 11'd2047);
		send_cmd(CMD_SET, 10'sd511, 11'd0);
		send_cmd(CMD_QUICK, 10'sd0, 11'd0);
		send_cmd(CMD_TICK, 10'sd0, 11'd0);
		send_cmd(CMD_SET, -10'sd512, 11'd1);
		send_cmd(CMD_QUICK, 10'sd0, 11'd0);
		send_cmd(CMD_TICK, 10'sd0, 11'd0);
		send_cmd(CMD_SET, 10'sd0, 11'd3);
		send_cmd(CMD_TICK, 10'sd0, 11'd0);
		send_cmd(CMD_SET, 10'sd0, 11'd2047);
		send_cmd(CMD_TICK, 10'sd0, 11'd0);
		send_cmd(CMD_TICK, 10'sd0, 11'd0);
		drain_results();
		// Inverted window: the lower bound is above the upper one.
		write_window(50, -50);
		send_cmd(CMD_SET, 10'sd10, 11'd2047);
		send_cmd(CMD_TICK, 10'sd0, 11'd0);
		send_cmd(CMD_TICK, 10'sd0, 11'd0);

		for (p = 0; p < 10; p++) begin
			drain_results();
			case (p)
				0: write_window(-42, 90);
				1: write_window(-512, 511);
				2: write_window(511, -512);
				3: write_window(0, 0);
				4: write_window(-512, -512);
				5: write_window(511, 511);
				6, 8: begin
					lo = int'($urandom_range(1023)) - 512;
					hi = lo + int'($urandom_range(511 - lo));
					write_window(lo, hi);
				end
				7: write_window(int'($urandom_range(1023)) - 512,
				                int'($urandom_range(1023)) - 512);
				default: write_window(-100, 100);
			endcase
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
				default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
			endcase
			// The receiver holds off long enough for the pipeline to fill and
			// push back on the input while transfers are still being offered.
			if (p == 0)
				hold_cycles = 120;
			run_random(88);
			if (p == 5)
				drain_results();
			run_random(87);
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0d results never arrived", sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== servo_position_ramp.f =====
rtl/spr_pkg.sv
rtl/servo_position_ramp.sv
verif/tb_servo_position_ramp.sv
